>>> design/laead_pkg.sv
// ----------------------------------------------------------------------------
// laead_pkg
// Shared types, constants and round logic for the lightweight AEAD encrypt core
// ----------------------------------------------------------------------------
package laead_pkg;

  typedef struct packed {
    logic [63:0] x0;
    logic [63:0] x1;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] x4;
  } lanes_t;

  localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // request types
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_AD    = 2'd1;
  localparam logic [1:0] REQ_PT    = 2'd2;

  // result kinds
  localparam logic KIND_CT  = 1'b0;
  localparam logic KIND_TAG = 1'b1;

  // configuration register indexes
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  localparam logic [3:0] FIRST_ROUND_FULL = 4'd0;
  localparam logic [3:0] FIRST_ROUND_HALF = 4'd6;
  localparam logic [3:0] LAST_ROUND       = 4'd11;
  localparam logic [3:0] FULL_BLOCK       = 4'd8;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction

  // one permutation round, r is the round index 0..11
  function automatic lanes_t perm_round(input lanes_t s, input logic [3:0] r);
    logic [63:0] a, b, c, d, e, t0, t1, t2, t3, t4;
    lanes_t o;
    a = s.x0;
    b = s.x1;
    d = s.x3;
    e = s.x4;
    c = s.x2 ^ {56'd0, ~r, r};
    a = a ^ e;
    e = e ^ d;
    c = c ^ b;
    t0 = a ^ (~b & c);
    t1 = b ^ (~c & d);
    t2 = c ^ (~d & e);
    t3 = d ^ (~e & a);
    t4 = e ^ (~a & b);
    t1 = t1 ^ t0;
    t0 = t0 ^ t4;
    t3 = t3 ^ t2;
    t2 = ~t2;
    o.x0 = t0 ^ ror64(t0, 19) ^ ror64(t0, 28);
    o.x1 = t1 ^ ror64(t1, 61) ^ ror64(t1, 39);
    o.x2 = t2 ^ ror64(t2, 1) ^ ror64(t2, 6);
    o.x3 = t3 ^ ror64(t3, 10) ^ ror64(t3, 17);
    o.x4 = t4 ^ ror64(t4, 7) ^ ror64(t4, 41);
    perm_round = o;
  endfunction

  // leading-byte mask, n in 0..8
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [6:0] sh;
    sh = {3'd0, FULL_BLOCK - n} << 3;
    if (n == 4'd0) begin
      byte_mask = 64'd0;
    end else if (n >= FULL_BLOCK) begin
      byte_mask = '1;
    end else begin
      byte_mask = {64{1'b1}} << sh;
    end
  endfunction

  // padding byte placed right after n valid bytes, n in 0..7
  function automatic logic [63:0] pad_word(input logic [2:0] n);
    logic [5:0] sh;
    sh = {3'd7 - n, 3'b000};
    pad_word = {56'd0, PAD_BYTE} << sh;
  endfunction

endpackage

>>> design/lightweight_aead_encrypt_core.sv
// ----------------------------------------------------------------------------
// lightweight_aead_encrypt_core
// Ascon-128 style authenticated encryption over a five-lane sponge state
// ----------------------------------------------------------------------------
// One permutation round is computed per clock by a single shared round unit,
// stepped by a round counter. A start request loads the state on accept and
// then runs rounds 0 to 11, with in_stall high until they are done. An
// associated-data block is absorbed on accept and runs rounds 6 to 11; a
// final associated-data block with eight bytes then runs the padded empty
// block through rounds 6 to 11 straight after, and an empty first
// associated-data block is done on accept with no rounds. A full plaintext
// block is absorbed on accept, hands its ciphertext to the output register,
// then runs rounds 6 to 11; the hand-off waits while that register still
// holds a stalled result. A final plaintext block with eight bytes then also
// runs rounds 0 to 11 and hands the tag to the output register; a shorter one
// skips rounds 6 to 11, an empty one has no ciphertext. The output register
// lets the next request be taken while a result still waits downstream. The
// key is to be written through the config port while idle; it is not enforced.
module lightweight_aead_encrypt_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_block_data,
  input  logic [63:0] in_nonce_second,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [63:0] out_word_a,
  output logic [63:0] out_word_b,
  output logic [3:0]  out_bytes,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);
  import laead_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PERM = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_INIT = 2'd1;
  localparam logic [1:0] P_AD   = 2'd2;
  localparam logic [1:0] P_PT   = 2'd3;

  // what follows the running permutation
  localparam logic [2:0] POST_INIT    = 3'd0;
  localparam logic [2:0] POST_AD_MID  = 3'd1;
  localparam logic [2:0] POST_AD_PAD0 = 3'd2;
  localparam logic [2:0] POST_AD_END  = 3'd3;
  localparam logic [2:0] POST_PT_MID  = 3'd4;
  localparam logic [2:0] POST_PT_PAD0 = 3'd5;
  localparam logic [2:0] POST_TAG     = 3'd6;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  round_r, round_nxt;
  logic [2:0]  post_r, post_nxt;
  lanes_t      lanes_r, lanes_nxt;
  logic [63:0] key_hi_r, key_lo_r;
  logic        pend_kind_r, pend_kind_nxt;
  logic [63:0] pend_word_r, pend_word_nxt;
  logic [3:0]  pend_bytes_r, pend_bytes_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [63:0] out_word_a_r, out_word_a_nxt;
  logic [63:0] out_word_b_r, out_word_b_nxt;
  logic [3:0]  out_bytes_r, out_bytes_nxt;
  logic        out_last_r, out_last_nxt;

  logic [3:0]  n_bytes;
  logic [63:0] in_mask;
  lanes_t      rnd_out;
  logic [63:0] x0_dat;

  // non-final blocks are always full, oversize counts saturate
  always_comb begin
    if (!in_last_block || in_valid_bytes > FULL_BLOCK) begin
      n_bytes = FULL_BLOCK;
    end else begin
      n_bytes = in_valid_bytes;
    end
  end

  assign in_mask = byte_mask(n_bytes);
  assign rnd_out = perm_round(lanes_r, round_r);
  assign x0_dat  = lanes_r.x0 ^ (in_block_data & in_mask);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    round_nxt      = round_r;
    post_nxt       = post_r;
    lanes_nxt      = lanes_r;
    pend_kind_nxt  = pend_kind_r;
    pend_word_nxt  = pend_word_r;
    pend_bytes_nxt = pend_bytes_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_word_a_nxt = out_word_a_r;
    out_word_b_nxt = out_word_b_r;
    out_bytes_nxt  = out_bytes_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_START: begin
              lanes_nxt = '{ASCON_IV, key_hi_r, key_lo_r, in_block_data, in_nonce_second};
              round_nxt = FIRST_ROUND_FULL;
              post_nxt  = POST_INIT;
              state_nxt = S_PERM;
            end
            REQ_AD: begin
              if (phase_r == P_INIT || phase_r == P_AD) begin
                if (phase_r == P_INIT && in_last_block && n_bytes == 4'd0) begin
                  // empty associated data: domain separation only
                  lanes_nxt.x4 = lanes_r.x4 ^ 64'd1;
                  phase_nxt    = P_PT;
                end else begin
                  round_nxt = FIRST_ROUND_HALF;
                  state_nxt = S_PERM;
                  if (n_bytes == FULL_BLOCK) begin
                    lanes_nxt.x0 = x0_dat;
                    post_nxt     = in_last_block ? POST_AD_PAD0 : POST_AD_MID;
                  end else begin
                    lanes_nxt.x0 = x0_dat ^ pad_word(n_bytes[2:0]);
                    post_nxt     = POST_AD_END;
                  end
                end
              end
            end
            REQ_PT: begin
              if (phase_r == P_INIT || phase_r == P_PT) begin
                if (phase_r == P_INIT) begin
                  lanes_nxt.x4 = lanes_r.x4 ^ 64'd1;
                end
                phase_nxt      = P_PT;
                pend_kind_nxt  = KIND_CT;
                pend_word_nxt  = x0_dat & in_mask;
                pend_bytes_nxt = n_bytes;
                state_nxt      = (n_bytes != 4'd0) ? S_EMIT : S_PERM;
                if (n_bytes == FULL_BLOCK) begin
                  lanes_nxt.x0 = x0_dat;
                  round_nxt    = FIRST_ROUND_HALF;
                  post_nxt     = in_last_block ? POST_PT_PAD0 : POST_PT_MID;
                end else begin
                  // padding lies past the ciphertext bytes, so it can go in now
                  lanes_nxt.x0 = x0_dat ^ pad_word(n_bytes[2:0]);
                  lanes_nxt.x1 = lanes_r.x1 ^ key_hi_r;
                  lanes_nxt.x2 = lanes_r.x2 ^ key_lo_r;
                  round_nxt    = FIRST_ROUND_FULL;
                  post_nxt     = POST_TAG;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PERM: begin
        lanes_nxt = rnd_out;
        round_nxt = round_r + 4'd1;
        if (round_r == LAST_ROUND) begin
          case (post_r)
            POST_INIT: begin
              lanes_nxt.x3 = rnd_out.x3 ^ key_hi_r;
              lanes_nxt.x4 = rnd_out.x4 ^ key_lo_r;
              phase_nxt    = P_INIT;
              state_nxt    = S_IDLE;
            end
            POST_AD_MID: begin
              phase_nxt = P_AD;
              state_nxt = S_IDLE;
            end
            POST_AD_PAD0: begin
              lanes_nxt.x0 = rnd_out.x0 ^ pad_word(3'd0);
              round_nxt    = FIRST_ROUND_HALF;
              post_nxt     = POST_AD_END;
            end
            POST_AD_END: begin
              lanes_nxt.x4 = rnd_out.x4 ^ 64'd1;
              phase_nxt    = P_PT;
              state_nxt    = S_IDLE;
            end
            POST_PT_MID: begin
              state_nxt = S_IDLE;
            end
            POST_PT_PAD0: begin
              lanes_nxt.x0 = rnd_out.x0 ^ pad_word(3'd0);
              lanes_nxt.x1 = rnd_out.x1 ^ key_hi_r;
              lanes_nxt.x2 = rnd_out.x2 ^ key_lo_r;
              round_nxt    = FIRST_ROUND_FULL;
              post_nxt     = POST_TAG;
            end
            POST_TAG: begin
              lanes_nxt.x3  = rnd_out.x3 ^ key_hi_r;
              lanes_nxt.x4  = rnd_out.x4 ^ key_lo_r;
              phase_nxt     = P_IDLE;
              pend_kind_nxt = KIND_TAG;
              state_nxt     = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pend_kind_r;
          out_word_a_nxt = (pend_kind_r == KIND_CT) ? pend_word_r : lanes_r.x3;
          out_word_b_nxt = (pend_kind_r == KIND_CT) ? 64'd0 : lanes_r.x4;
          out_bytes_nxt  = (pend_kind_r == KIND_CT) ? pend_bytes_r : 4'd0;
          out_last_nxt   = (pend_kind_r == KIND_TAG);
          state_nxt      = (pend_kind_r == KIND_CT) ? S_PERM : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_IDLE;
      out_valid_r <= 1'b0;
      lanes_r     <= '0;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      lanes_r     <= lanes_nxt;
      if (cfg_we && cfg_index == CFG_KEY_HIGH) begin
        key_hi_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_KEY_LOW) begin
        key_lo_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    round_r      <= round_nxt;
    post_r       <= post_nxt;
    pend_kind_r  <= pend_kind_nxt;
    pend_word_r  <= pend_word_nxt;
    pend_bytes_r <= pend_bytes_nxt;
    out_kind_r   <= out_kind_nxt;
    out_word_a_r <= out_word_a_nxt;
    out_word_b_r <= out_word_b_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_word_a = out_word_a_r;
  assign out_word_b = out_word_b_r;
  assign out_bytes  = out_bytes_r;
  assign out_last   = out_last_r;

endmodule

>>> design/laead_checker.sv
// ----------------------------------------------------------------------------
// laead_checker
// Port-level checks for the lightweight AEAD encrypt core
// ----------------------------------------------------------------------------
module laead_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [63:0] out_word_a,
  input logic [63:0] out_word_b,
  input logic [3:0]  out_bytes,
  input logic        out_last
);
  import laead_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_a) && $stable(out_word_b)
      && $stable(out_kind) && $stable(out_bytes) && $stable(out_last))
    else $error("stalled result changed");

  // ciphertext words carry one to eight bytes and no tag half
  a_ct_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CT |-> !out_last && out_word_b == 64'd0
      && out_bytes != 4'd0 && out_bytes <= 4'd8)
    else $error("malformed ciphertext result");

  // the tag closes the message
  a_tag_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TAG |-> out_last && out_bytes == 4'd0)
    else $error("malformed tag result");

  // reset leaves the core ready and the output empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("core not idle after reset");

endmodule

bind lightweight_aead_encrypt_core laead_checker u_laead_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_kind   (out_kind),
  .out_word_a (out_word_a),
  .out_word_b (out_word_b),
  .out_bytes  (out_bytes),
  .out_last   (out_last)
);
